[hdl/hsd_pkg.sv]
// Package for the descending sorter: shared constants, cell control and state types.
package hsd_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_DRAIN
  } st_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic ins;    // insert the incoming beat's value
    logic shift;  // move the row one place towards cell 0
  } cell_ctl_t;

endpackage

[hdl/heap_sort_descending.sv]
// Top level of the descending sorter: cell row, fill count and load/drain control.
//
//  channel | direction  | ports                                   | beat
//  --------+------------+-----------------------------------------+-------------------------
//  in_     | to block   | in_valid, in_stall, in_value, in_last   | one value of the set
//  out_    | from block | out_valid, out_stall, out_sorted_value, | one value, largest first
//          |            | out_final_res, out_overflowed           |
//
//  Load: in_stall stays low, so every input beat is taken; every cell compares the new value
//  at once and the row opens a gap in place, so the set is always held in decreasing order.
//  Drain: one result per cycle while out_stall is low, the first in the cycle after the
//  closing beat; in_stall stays high until the final beat. Reset (rst_n low, synchronous)
//  empties the row and clears the overflow flag; cell contents are kept, the fill count marks
//  live cells. The row shifts only on a taken beat.
module heap_sort_descending #(
  parameter int CAPACITY = hsd_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [hsd_pkg::DATA_W-1:0]  in_value,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [hsd_pkg::DATA_W-1:0]  out_sorted_value,
  output logic                               out_final_res,
  output logic                               out_overflowed
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  hsd_pkg::st_t      state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic              in_acc, out_acc, room;
  hsd_pkg::cell_ctl_t ctl;

  logic signed [hsd_pkg::DATA_W-1:0] cell_val  [CAPACITY];
  logic                              cell_keep [CAPACITY];
  logic                              cell_vld  [CAPACITY];

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign room    = count_r < CNT_W'(CAPACITY);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hsd_pkg::ST_LOAD: begin
        if (in_acc && in_last) begin
          state_nxt = hsd_pkg::ST_DRAIN;
        end
      end
      hsd_pkg::ST_DRAIN: begin
        if (out_acc && out_final_res) begin
          state_nxt = hsd_pkg::ST_LOAD;
        end
      end
      default: state_nxt = hsd_pkg::ST_LOAD;
    endcase
  end

  // handshake and row control
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    ctl.ins   = 1'b0;
    ctl.shift = 1'b0;
    case (state_r)
      hsd_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        ctl.ins  = in_acc && room;
      end
      hsd_pkg::ST_DRAIN: begin
        out_valid = 1'b1;
        ctl.shift = out_acc;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // fill count and overflow flag
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (in_acc && !room) begin
      ovf_nxt = 1'b1;   // full store: value dropped
    end
    if (out_acc) begin
      count_nxt = count_r - CNT_W'(1);
      if (out_final_res) begin
        ovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsd_pkg::ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // row of cells, cell 0 holds the largest value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                              prev_keep;
    logic signed [hsd_pkg::DATA_W-1:0] prev_value;
    logic signed [hsd_pkg::DATA_W-1:0] next_value;

    assign cell_vld[i] = count_r > CNT_W'(i);

    if (i == 0) begin : g_head
      assign prev_keep  = 1'b1;
      assign prev_value = in_value;
    end else begin : g_mid
      assign prev_keep  = cell_keep[i-1];
      assign prev_value = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = '0;
    end else begin : g_body
      assign next_value = cell_val[i+1];
    end

    hsd_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cell_valid (cell_vld[i]),
      .in_value   (in_value),
      .prev_keep  (prev_keep),
      .prev_value (prev_value),
      .next_value (next_value),
      .keep       (cell_keep[i]),
      .value      (cell_val[i])
    );
  end

  assign out_sorted_value = cell_val[0];
  assign out_final_res    = count_r == CNT_W'(1);
  assign out_overflowed   = ovf_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (cell_val[0] >= cell_val[1]))
    else $error("row head out of order");

  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !room) |=> ovf_r)
    else $error("dropped value not flagged");

  a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_final_res) |=>
      (count_r == '0 && !ovf_r && state_r == hsd_pkg::ST_LOAD))
    else $error("set not closed after final beat");
`endif

endmodule

[hdl/hsd_cell.sv]
// One sorting cell: holds one value, inserts or passes it along the row.
module hsd_cell (
  input  logic                               clk,
  input  hsd_pkg::cell_ctl_t                 ctl,
  input  logic                               cell_valid,
  input  logic signed [hsd_pkg::DATA_W-1:0]  in_value,
  input  logic                               prev_keep,
  input  logic signed [hsd_pkg::DATA_W-1:0]  prev_value,
  input  logic signed [hsd_pkg::DATA_W-1:0]  next_value,
  output logic                               keep,
  output logic signed [hsd_pkg::DATA_W-1:0]  value
);

  logic signed [hsd_pkg::DATA_W-1:0] value_r;
  logic signed [hsd_pkg::DATA_W-1:0] value_nxt;

  // an occupied cell at least as large as the new value stays put
  assign keep  = cell_valid && (value_r >= in_value);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctl.shift) begin
      value_nxt = next_value;
    end else if (ctl.ins && !keep) begin
      if (prev_keep) begin
        value_nxt = in_value;
      end else begin
        value_nxt = prev_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

[tb/tb_top.sv]
// Self-checking bench for the descending sorter: directed table, random sets, stall pressure.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  DATA_W       = hsd_pkg::DATA_W;
  localparam int  HALF_PERIOD  = 4;
  localparam int  STORE_DEPTH  = hsd_pkg::CAPACITY_DEF;
  localparam int  ITEM_TARGET  = 330;
  localparam int  LONG_HOLD    = 400;   // receiver hold-off, in cycles
  localparam int  SETTLE       = 20;    // quiet cycles after the last result
  localparam time RUN_LIMIT    = 2_000_000ns;

  // idling modes, walked in this order
  typedef enum int {
    MODE_SENDER_LIGHT,   // sender idles 11 %, receiver 58 %
    MODE_RECEIVER_LIGHT, // sender idles 58 %, receiver 11 %
    MODE_FLAT_OUT        // nobody idles
  } idle_mode_t;

  // one expected result beat
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflowed;
  } sorted_beat_t;

  // one row of the directed table; pinned rows carry their own expectation
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     pinned;
  } stim_row_t;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_value  = '0;
  logic                     in_last   = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic                     out_final_res;
  logic                     out_overflowed;

  // predictor state: the open set, kept in decreasing order as it arrives
  logic signed [DATA_W-1:0] open_set[$];
  logic                     set_dropped = 1'b0;

  // results still owed by the block, oldest first
  sorted_beat_t             pending_sorted[$];

  idle_mode_t idle_mode     = MODE_SENDER_LIGHT;
  int         snd_idle_pct  = 11;
  int         rcv_idle_pct  = 58;
  bit         hold_done     = 1'b0;
  int         fault_count   = 0;
  int         items_sent    = 0;

  // Directed part. Single-value sets are pinned: the value comes straight back,
  // marked final and not overflowed. Longer sets go through the predictor.
  stim_row_t directed_rows[23] = '{
    '{32'sh7fffffff, 1'b1, 1'b1},   // lone maximum
    '{32'sh80000000, 1'b1, 1'b1},   // lone minimum
    '{32'sh00000000, 1'b1, 1'b1},   // lone zero
    '{32'shffffffff, 1'b1, 1'b1},   // lone minus one
    '{32'sh00000005, 1'b0, 1'b0},   // mixed signs with both extremes
    '{-32'sd3,       1'b0, 1'b0},
    '{32'sh7fffffff, 1'b0, 1'b0},
    '{32'sh80000000, 1'b0, 1'b0},
    '{32'shffffffff, 1'b1, 1'b0},
    '{32'sh00000007, 1'b0, 1'b0},   // duplicates
    '{32'sh00000007, 1'b0, 1'b0},
    '{-32'sd7,       1'b0, 1'b0},
    '{32'sh00000007, 1'b1, 1'b0},
    '{32'sh00000001, 1'b0, 1'b0},   // arrives ascending
    '{32'sh00000002, 1'b0, 1'b0},
    '{32'sh00000003, 1'b0, 1'b0},
    '{32'sh00000004, 1'b1, 1'b0},
    '{32'sh00000004, 1'b0, 1'b0},   // arrives already descending
    '{32'sh00000003, 1'b0, 1'b0},
    '{32'sh00000002, 1'b0, 1'b0},
    '{32'sh00000001, 1'b1, 1'b0},
    '{32'sh80000000, 1'b0, 1'b0},   // pair of minima
    '{32'sh80000000, 1'b1, 1'b0}
  };

  heap_sort_descending i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_overflowed   (out_overflowed)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Predictor. Insertion keeps the set in decreasing order, so closing the set
  // just reads it out front to back. Once the store is full, further values
  // (the closing one too) are lost and every result of the set says so.
  function automatic void sort_into_set(input logic signed [DATA_W-1:0] v,
                                        input logic closing, input logic pinned);
    int pos;
    if (open_set.size() < STORE_DEPTH) begin
      pos = 0;
      while (pos < open_set.size() && open_set[pos] >= v) pos++;
      open_set.insert(pos, v);
    end else begin
      set_dropped = 1'b1;
    end
    if (closing) begin
      if (pinned) begin
        pending_sorted.push_back('{v, 1'b1, 1'b0});
      end else begin
        foreach (open_set[k])
          pending_sorted.push_back('{open_set[k], k == open_set.size() - 1, set_dropped});
      end
      open_set.delete();
      set_dropped = 1'b0;
    end
  endfunction

  // Offer one beat, with the sender's idle cycles ahead of it, and return once
  // it has been taken. in_valid is left high so back-to-back beats stay seamless.
  task automatic drive_beat(input logic signed [DATA_W-1:0] v, input logic closing,
                            input logic pinned);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= closing;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sort_into_set(v, closing, pinned);
    items_sent++;
  endtask

  // Sender pause: nothing more is offered until every owed result is out.
  task automatic await_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sorted.size() != 0) @(posedge clk);
  endtask

  // Value mix: extremes, a narrow band to force ties, and full-range noise.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7fffffff;
          1:       return 32'sh80000000;
          2:       return 32'sh00000000;
          default: return 32'shffffffff;
        endcase
      end
      1:       return $signed($urandom_range(0, 8)) - 4;
      default: return $signed($urandom);
    endcase
  endfunction

  // Mostly short sets; the second set fills the store exactly and the fourth
  // overruns it, with the odd set near or past the store's depth at random later on.
  function automatic int pick_set_size(input int set_idx);
    int r;
    if (set_idx == 1) return STORE_DEPTH;
    if (set_idx == 3) return STORE_DEPTH + 3;
    r = $urandom_range(0, 39);
    if (r == 0) return $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 4);
    if (r < 8)  return $urandom_range(9, 30);
    return $urandom_range(1, 8);
  endfunction

  function automatic void set_idle_mode(input idle_mode_t m);
    idle_mode = m;
    case (m)
      MODE_SENDER_LIGHT: begin
        snd_idle_pct = 11;
        rcv_idle_pct = 58;
      end
      MODE_RECEIVER_LIGHT: begin
        snd_idle_pct = 58;
        rcv_idle_pct = 11;
      end
      default: begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic signed [DATA_W-1:0] want,
                                      input logic signed [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endfunction

  // Stimulus: reset, directed table, then random sets walked through the idling modes.
  initial begin : stimulus
    int         set_idx;
    int         set_len;
    idle_mode_t next_mode;
    set_idle_mode(MODE_SENDER_LIGHT);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      drive_beat(directed_rows[i].value, directed_rows[i].last, directed_rows[i].pinned);

    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      // switch modes only on set boundaries, letting the block drain first
      next_mode = items_sent < 110 ? MODE_SENDER_LIGHT :
                  items_sent < 220 ? MODE_RECEIVER_LIGHT : MODE_FLAT_OUT;
      if (next_mode != idle_mode) begin
        await_drain();
        set_idle_mode(next_mode);
      end
      set_len = pick_set_size(set_idx);
      for (int k = 0; k < set_len; k++)
        drive_beat(pick_value(), k == set_len - 1, 1'b0);
      set_idx++;
    end

    await_drain();
    repeat (SETTLE) @(posedge clk);
    if (fault_count == 0 && pending_sorted.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Receiver: random back-pressure per mode. On entering the flat-out mode it
  // holds off for a long stretch while the sender keeps offering, so the block
  // sits on a finished set with its input stalled.
  initial begin : receiver
    int held_cycles;
    forever begin
      @(posedge clk);
      if (idle_mode == MODE_FLAT_OUT && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        for (held_cycles = 0; held_cycles < LONG_HOLD; held_cycles++) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // Result monitor: every taken beat is matched against the oldest owed result.
  always @(posedge clk) begin : result_check
    sorted_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sorted.size() == 0) begin
        $error("unexpected result beat: sorted_value %0d", out_sorted_value);
        fault_count++;
      end else begin
        want = pending_sorted.pop_front();
        check_field("sorted_value", want.sorted_value, out_sorted_value);
        check_field("final_res", DATA_W'(want.final_res), DATA_W'(out_final_res));
        check_field("overflowed", DATA_W'(want.overflowed), DATA_W'(out_overflowed));
      end
    end
  end

  // Backstop against a hung handshake.
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("tb_top failed");
    $finish;
  end

endmodule

[sim.f]
hdl/hsd_pkg.sv
hdl/hsd_cell.sv
hdl/heap_sort_descending.sv
tb/tb_top.sv
